### sv/pss_pkg.sv
package pss_pkg;

  localparam int ID_BITS     = 12;
  localparam int ID_SPACE    = 1 << ID_BITS;
  localparam int VALUE_BITS  = 32;
  localparam int SLOT_BITS   = 12;
  localparam int LIVE_BITS   = 13;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int IN_PAD_W    = IN_TDATA_W - ID_BITS - VALUE_BITS;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_BITS - SLOT_BITS - LIVE_BITS;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_WRITE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_CAPTURE,
    DP_LOOKUP,
    DP_INSERT,
    DP_DUP,
    DP_FULL,
    DP_ABSENT,
    DP_MOVE,
    DP_UNLINK,
    DP_WRITE,
    DP_RDISSUE,
    DP_RDTAKE,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic present;
    logic full;
    logic out_busy;
    logic clr_last;
  } dp_status_t;

endpackage

### sv/pss_ctrl.sv
module pss_ctrl
  import pss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_UNLINK,
    S_RDATA,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_IDLE;
    unique case (state_r)
      S_INIT: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.op    = DP_LOOKUP;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        priority if (stat.action == ACT_INSERT) begin
          priority if (stat.present) begin
            cmd.op = DP_DUP;
          end else if (stat.full) begin
            cmd.op = DP_FULL;
          end else begin
            cmd.op = DP_INSERT;
          end
        end else if (!stat.present) begin
          cmd.op = DP_ABSENT;
        end else begin
          unique case (stat.action)
            ACT_REMOVE: begin
              cmd.op    = DP_MOVE;
              state_nxt = S_UNLINK;
            end
            ACT_READ: begin
              cmd.op    = DP_RDISSUE;
              state_nxt = S_RDATA;
            end
            default: begin
              cmd.op = DP_WRITE;
            end
          endcase
        end
      end
      S_UNLINK: begin
        cmd.op    = DP_UNLINK;
        state_nxt = S_RESP;
      end
      S_RDATA: begin
        cmd.op    = DP_RDTAKE;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.op    = DP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/pss_dpath.sv
module pss_dpath
  import pss_pkg::*;
#(
  parameter int MAX_ITEMS = 4096,
  parameter int DATA_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output dp_status_t             stat,
  input  logic [1:0]             in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SLOT_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SP_W   = SLOT_W + 1;

  logic [SP_W-1:0]      sparse_mem [ID_SPACE];
  logic [ID_BITS-1:0]   did_mem    [MAX_ITEMS];
  logic [DATA_BITS-1:0] ddat_mem   [MAX_ITEMS];

  act_t                 act_r;
  logic [ID_BITS-1:0]   id_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ID_BITS-1:0]   clr_idx_r;
  logic [SP_W-1:0]      sp_q_r;
  logic [ID_BITS-1:0]   did_q_r;
  logic [DATA_BITS-1:0] dd_q_r;
  stat_t                res_status_r;
  logic [VALUE_BITS-1:0] res_rd_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 out_valid_r;
  stat_t                out_status_r;
  logic [VALUE_BITS-1:0] out_rd_r;
  logic [SLOT_BITS-1:0] out_slot_r;
  logic [LIVE_BITS-1:0] out_live_r;

  logic [SLOT_W-1:0]    sp_slot;
  logic [SLOT_W-1:0]    last_slot;
  logic [SLOT_W-1:0]    cnt_slot;
  logic                 sp_we;
  logic [ID_BITS-1:0]   sp_waddr;
  logic [SP_W-1:0]      sp_wdata;
  logic                 di_we;
  logic [SLOT_W-1:0]    di_waddr;
  logic [ID_BITS-1:0]   di_wdata;
  logic                 dd_we;
  logic [SLOT_W-1:0]    dd_waddr;
  logic [DATA_BITS-1:0] dd_wdata;
  logic [SLOT_W-1:0]    dd_raddr;

  assign sp_slot   = sp_q_r[SLOT_W-1:0];
  assign last_slot = SLOT_W'(cnt_r - 1'b1);
  assign cnt_slot  = SLOT_W'(cnt_r);
  assign dd_raddr  = (cmd.op == DP_RDISSUE) ? sp_slot : last_slot;

  assign stat.action   = act_r;
  assign stat.present  = sp_q_r[SLOT_W];
  assign stat.full     = (cnt_r == CNT_W'(MAX_ITEMS));
  assign stat.out_busy = out_valid_r && !out_tready;
  assign stat.clr_last = (clr_idx_r == '1);

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = id_r;
    sp_wdata = '0;
    di_we    = 1'b0;
    di_waddr = sp_slot;
    di_wdata = did_q_r;
    dd_we    = 1'b0;
    dd_waddr = sp_slot;
    dd_wdata = dd_q_r;
    unique case (cmd.op)
      DP_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr_idx_r;
      end
      DP_INSERT: begin
        sp_we    = 1'b1;
        sp_wdata = {1'b1, cnt_slot};
        di_we    = 1'b1;
        di_waddr = cnt_slot;
        di_wdata = id_r;
        dd_we    = 1'b1;
        dd_waddr = cnt_slot;
        dd_wdata = DATA_BITS'(val_r);
      end
      DP_MOVE: begin
        sp_we    = 1'b1;
        sp_waddr = did_q_r;
        sp_wdata = {1'b1, sp_slot};
        di_we    = 1'b1;
        dd_we    = 1'b1;
      end
      DP_UNLINK: begin
        sp_we = 1'b1;
      end
      DP_WRITE: begin
        dd_we    = 1'b1;
        dd_wdata = DATA_BITS'(val_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sparse_mem[sp_waddr] <= sp_wdata;
    end
    sp_q_r <= sparse_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (di_we) begin
      did_mem[di_waddr] <= di_wdata;
    end
    did_q_r <= did_mem[last_slot];
  end

  always_ff @(posedge clk) begin
    if (dd_we) begin
      ddat_mem[dd_waddr] <= dd_wdata;
    end
    dd_q_r <= ddat_mem[dd_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      act_r <= act_t'(in_tuser);
      id_r  <= in_tdata[ID_BITS-1:0];
      val_r <= in_tdata[ID_BITS +: VALUE_BITS];
    end
    unique case (cmd.op)
      DP_INSERT: begin
        res_status_r <= ST_OK;
        res_rd_r     <= '0;
        res_slot_r   <= cnt_slot;
      end
      DP_DUP: begin
        res_status_r <= ST_PRESENT;
        res_rd_r     <= '0;
        res_slot_r   <= sp_slot;
      end
      DP_FULL: begin
        res_status_r <= ST_FULL;
        res_rd_r     <= '0;
        res_slot_r   <= '0;
      end
      DP_ABSENT: begin
        res_status_r <= ST_ABSENT;
        res_rd_r     <= '0;
        res_slot_r   <= '0;
      end
      DP_MOVE, DP_WRITE, DP_RDISSUE: begin
        res_status_r <= ST_OK;
        res_rd_r     <= '0;
        res_slot_r   <= sp_slot;
      end
      DP_RDTAKE: begin
        res_rd_r <= VALUE_BITS'(dd_q_r);
      end
      default: begin
      end
    endcase
    if (cmd.op == DP_RESP) begin
      out_status_r <= res_status_r;
      out_rd_r     <= res_rd_r;
      out_slot_r   <= SLOT_BITS'(res_slot_r);
      out_live_r   <= LIVE_BITS'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == DP_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.op == DP_INSERT) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.op == DP_UNLINK) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.op == DP_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_live_r, out_slot_r, out_rd_r};

endmodule

### sv/packed_sparse_set_table.sv
// Packed sparse-set table keyed by a 12-bit entity id.
// Input channel in_*: one transaction per operation. in_tuser carries the
// action (insert, remove, read, write), in_tdata the entity id and data word.
// Output channel out_*: exactly one transaction per input transaction, in
// order. out_tuser carries the status code, out_tdata the read data, the
// dense slot and the live entry count.
// Sequence: insert, write and every rejected operation pass through lookup,
// decide and response; a successful remove adds an unlink step and a
// successful read a read-data step before the response. One operation is
// in flight at a time, so a new transaction is taken only once the last
// has loaded its result; the chained reads of the sparse map and the dense
// arrays are each a registered memory read.
// Reset: entry count and output are cleared, then a sweep over all 4096 ids
// clears the presence bits of the sparse map; in_tready stays low meanwhile.
// Stall: a finished result waits in the output register; the next input is
// still accepted and processed, and the block holds before loading its
// result until out_tready frees the register.
module packed_sparse_set_table
  import pss_pkg::*;
#(
  parameter int MAX_ITEMS = 4096,
  parameter int DATA_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [1:0]             in_tuser,   // action
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entity_id, value, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_tuser,  // status
  output logic [OUT_TDATA_W-1:0] out_tdata   // read_value, dense_slot, live_count, zero pad
);

  cmd_t       cmd;
  dp_status_t stat;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pss_dpath #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> cmd.op == DP_LOOKUP)
    else $error("accepted transaction not followed by lookup");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ABSENT || out_tuser == ST_FULL)
      |-> out_tdata[VALUE_BITS +: SLOT_BITS] == '0)
    else $error("nonzero slot on absent or full status");

  a_fail_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[VALUE_BITS-1:0] == '0)
    else $error("nonzero read data on failed operation");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == DP_RESP))
    else $error("output valid without response load");

endmodule

### verif/tb_packed_sparse_set_table.sv
module tb_packed_sparse_set_table;
  import pss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int FILL_IDS    = 48;

  typedef struct {
    stat_t             status;
    logic [31:0]       rdata;
    logic [SLOT_BITS-1:0] slot;
    logic [LIVE_BITS-1:0] live;
  } op_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [1:0]             in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [1:0]             out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;

  packed_sparse_set_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  // table model
  bit                   is_live [ID_SPACE];
  logic [SLOT_BITS-1:0] slot_by_id [ID_SPACE];
  logic [ID_BITS-1:0]   id_by_slot [TABLE_DEPTH];
  logic [31:0]          word_by_slot [TABLE_DEPTH];
  int                   live_entries = 0;
  int                   peak_entries = 0;

  op_result_t pending_results[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         actions_sent [4];
  int         statuses_seen [4];
  bit         burst = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_seen = 1'b0;
  int         hold_left = 0;
  logic [ID_BITS-1:0] id_pool [16];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic op_result_t apply_to_table(act_t act, logic [ID_BITS-1:0] id,
                                                logic [31:0] val);
    op_result_t r;
    logic [SLOT_BITS-1:0] last;
    logic [ID_BITS-1:0] moved;
    r.status = ST_OK;
    r.rdata = '0;
    r.slot = '0;
    if (act == ACT_INSERT) begin
      if (is_live[id]) begin
        r.status = ST_PRESENT;
        r.slot = slot_by_id[id];
      end else if (live_entries >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        r.slot = live_entries[SLOT_BITS-1:0];
        slot_by_id[id] = r.slot;
        id_by_slot[r.slot] = id;
        word_by_slot[r.slot] = val;
        is_live[id] = 1'b1;
        live_entries++;
      end
    end else if (!is_live[id]) begin
      r.status = ST_ABSENT;
    end else begin
      r.slot = slot_by_id[id];
      case (act)
        ACT_REMOVE: begin
          last = SLOT_BITS'(live_entries - 1);
          moved = id_by_slot[last];
          word_by_slot[r.slot] = word_by_slot[last];
          slot_by_id[moved] = r.slot;
          id_by_slot[r.slot] = moved;
          is_live[id] = 1'b0;
          live_entries--;
        end
        ACT_READ: r.rdata = word_by_slot[r.slot];
        default: word_by_slot[r.slot] = val;
      endcase
    end
    r.live = live_entries[LIVE_BITS-1:0];
    if (live_entries > peak_entries) peak_entries = live_entries;
    return r;
  endfunction

  task automatic send_op(act_t act, logic [ID_BITS-1:0] id, logic [31:0] val);
    while (!burst && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{IN_PAD_W{1'b0}}, val, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    actions_sent[act]++;
    pending_results.push_back(apply_to_table(act, id, val));
  endtask

  function automatic act_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 30) return ACT_INSERT;
    if (r < 55) return ACT_REMOVE;
    if (r < 80) return ACT_READ;
    return ACT_WRITE;
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 45 && live_entries > 0) return id_by_slot[$urandom_range(live_entries - 1)];
    if (r < 80) return id_pool[$urandom_range(15)];
    return ID_BITS'($urandom_range(ID_SPACE - 1));
  endfunction

  task automatic test_empty_table();
    send_op(ACT_READ, '0, 32'h1234_5678);
    send_op(ACT_WRITE, '1, '1);
    send_op(ACT_REMOVE, '0, '0);
    send_op(ACT_REMOVE, '1, '0);
  endtask

  task automatic test_directed_ops();
    send_op(ACT_INSERT, '0, '0);
    send_op(ACT_INSERT, '1, '1);
    send_op(ACT_INSERT, '0, 32'hDEAD_BEEF);
    send_op(ACT_READ, '0, '1);
    send_op(ACT_READ, '1, '0);
    send_op(ACT_WRITE, '0, 32'hA5A5_5A5A);
    send_op(ACT_READ, '0, '0);
    send_op(ACT_INSERT, 12'hAAA, 32'h5555_5555);
    send_op(ACT_INSERT, 12'h555, 32'hAAAA_AAAA);
    send_op(ACT_REMOVE, '0, '1);
    send_op(ACT_READ, 12'h555, '0);
    send_op(ACT_READ, '0, '0);
    send_op(ACT_WRITE, '0, '1);
    send_op(ACT_REMOVE, 12'h555, '0);
    send_op(ACT_REMOVE, 12'h555, '0);
    send_op(ACT_READ, 12'hAAA, '0);
  endtask

  task automatic test_remove_last();
    send_op(ACT_INSERT, 12'h800, 32'h8000_0001);
    send_op(ACT_REMOVE, 12'h800, '0);
    send_op(ACT_READ, 12'h800, '0);
    send_op(ACT_INSERT, 12'h800, 32'h0000_0002);
    send_op(ACT_READ, 12'h800, '0);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) burst = 1'b1;
      if (i == count / 3 + 80) burst = 1'b0;
      send_op(pick_action(), pick_id(), $urandom);
    end
  endtask

  task automatic test_backpressure();
    hold_req <= ~hold_req;
    burst = 1'b1;
    for (int i = 0; i < 40; i++) send_op(pick_action(), pick_id(), $urandom);
    burst = 1'b0;
  endtask

  task automatic test_fill_and_drain();
    int order [ID_SPACE];
    int j;
    int tmp;
    for (int i = 0; i < ID_SPACE; i++) order[i] = i;
    for (int i = ID_SPACE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    burst = 1'b1;
    for (int i = 0; i < FILL_IDS; i++) begin
      if (!is_live[order[i]]) send_op(ACT_INSERT, ID_BITS'(order[i]), $urandom);
    end
    burst = 1'b0;
    send_op(ACT_INSERT, ID_BITS'(order[0]), $urandom);
    for (int i = 0; i < 20; i++) begin
      send_op(($urandom_range(1) != 0) ? ACT_READ : ACT_WRITE, pick_id(), $urandom);
    end
    send_op(ACT_REMOVE, ID_BITS'(order[5]), '0);
    send_op(ACT_INSERT, ID_BITS'(order[5]), '1);
    for (int i = 0; i < FILL_IDS; i++) begin
      if ($urandom_range(9) == 0) send_op(ACT_READ, pick_id(), '0);
      send_op(ACT_REMOVE, ID_BITS'(order[i]), $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= burst || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    op_result_t want;
    op_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = stat_t'(out_tuser);
      got.rdata  = out_tdata[VALUE_BITS-1:0];
      got.slot   = out_tdata[VALUE_BITS +: SLOT_BITS];
      got.live   = out_tdata[VALUE_BITS + SLOT_BITS +: LIVE_BITS];
      statuses_seen[got.status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transaction: status %s slot %0d live %0d",
                   got.status.name(), got.slot, got.live);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.rdata !== want.rdata ||
            got.slot !== want.slot || got.live !== want.live) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %s data %h slot %0d live %0d",
                     want.status.name(), want.rdata, want.slot, want.live);
            $display("                 actual   %s data %h slot %0d live %0d",
                     got.status.name(), got.rdata, got.slot, got.live);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = 12'h001;
    id_pool[3] = 12'hFFE;
    for (int i = 4; i < 16; i++) id_pool[i] = ID_BITS'($urandom_range(ID_SPACE - 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_ops();
    test_remove_last();
    test_random_mix(280);
    test_backpressure();
    test_fill_and_drain();
    test_random_mix(40);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ops sent: insert %0d, remove %0d, read %0d, write %0d; peak live entries %0d",
             actions_sent[ACT_INSERT], actions_sent[ACT_REMOVE],
             actions_sent[ACT_READ], actions_sent[ACT_WRITE], peak_entries);
    $display("statuses seen: ok %0d, absent %0d, duplicate %0d, full %0d; mismatches %0d",
             statuses_seen[ST_OK], statuses_seen[ST_ABSENT],
             statuses_seen[ST_PRESENT], statuses_seen[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
